// ===== src/sc1a_pkg.sv =====
`default_nettype none

package sc1a_pkg;

  localparam logic [7:0] PREFIX_BYTE = 8'hE0;
  localparam int unsigned IdWidth    = 7;
  localparam int unsigned CharWidth  = 7;

  localparam logic [IdWidth-1:0] ID_LCTRL  = 7'h1D;
  localparam logic [IdWidth-1:0] ID_LSHIFT = 7'h2A;
  localparam logic [IdWidth-1:0] ID_RSHIFT = 7'h36;
  localparam logic [IdWidth-1:0] ID_LALT   = 7'h38;
  localparam logic [IdWidth-1:0] ID_CAPS   = 7'h3A;
  localparam logic [IdWidth-1:0] ID_NUMLK  = 7'h45;
  localparam logic [IdWidth-1:0] ID_INSERT = 7'h52;
  localparam logic [IdWidth-1:0] PAD_LOW   = 7'h47;
  localparam logic [IdWidth-1:0] PAD_HIGH  = 7'h53;

  localparam logic [CharWidth-1:0] LETTER_CASE_STEP = 7'h20;

  typedef enum logic [1:0] {
    KIND_PRESS       = 2'd0,
    KIND_RELEASE     = 2'd1,
    KIND_SPC_PRESS   = 2'd2,
    KIND_SPC_RELEASE = 2'd3
  } event_kind_e;

  typedef struct packed {
    logic shift;
    logic ctrl;
    logic alt;
    logic caps;
    logic num;
    logic ins;
  } flags_t;

  typedef struct packed {
    logic                  emit;
    logic                  ext_next;
    flags_t                flags_next;
    logic [IdWidth-1:0]    key_id;
    event_kind_e           kind;
    logic [CharWidth-1:0]  ascii_char;
  } decode_t;

  function automatic logic [CharWidth-1:0] lower_char(input logic [IdWidth-1:0] id);
    logic [CharWidth-1:0] c;
    unique case (id)
      7'h02: c = 7'h31; 7'h03: c = 7'h32; 7'h04: c = 7'h33; 7'h05: c = 7'h34;
      7'h06: c = 7'h35; 7'h07: c = 7'h36; 7'h08: c = 7'h37; 7'h09: c = 7'h38;
      7'h0A: c = 7'h39; 7'h0B: c = 7'h30; 7'h0C: c = 7'h2D; 7'h0D: c = 7'h3D;
      7'h0E: c = 7'h08; 7'h0F: c = 7'h09;
      7'h10: c = 7'h71; 7'h11: c = 7'h77; 7'h12: c = 7'h65; 7'h13: c = 7'h72;
      7'h14: c = 7'h74; 7'h15: c = 7'h79; 7'h16: c = 7'h75; 7'h17: c = 7'h69;
      7'h18: c = 7'h6F; 7'h19: c = 7'h70; 7'h1A: c = 7'h5B; 7'h1B: c = 7'h5D;
      7'h1C: c = 7'h0A; 7'h1E: c = 7'h61; 7'h1F: c = 7'h73;
      7'h20: c = 7'h64; 7'h21: c = 7'h66; 7'h22: c = 7'h67; 7'h23: c = 7'h68;
      7'h24: c = 7'h6A; 7'h25: c = 7'h6B; 7'h26: c = 7'h6C; 7'h27: c = 7'h3B;
      7'h28: c = 7'h27; 7'h29: c = 7'h60; 7'h2B: c = 7'h5C; 7'h2C: c = 7'h7A;
      7'h2D: c = 7'h78; 7'h2E: c = 7'h63; 7'h2F: c = 7'h76;
      7'h30: c = 7'h62; 7'h31: c = 7'h6E; 7'h32: c = 7'h6D; 7'h33: c = 7'h2C;
      7'h34: c = 7'h2E; 7'h35: c = 7'h2F; 7'h37: c = 7'h2A; 7'h39: c = 7'h20;
      7'h47: c = 7'h37; 7'h48: c = 7'h38; 7'h49: c = 7'h39; 7'h4A: c = 7'h2D;
      7'h4B: c = 7'h34; 7'h4C: c = 7'h35; 7'h4D: c = 7'h36; 7'h4E: c = 7'h2B;
      7'h4F: c = 7'h31; 7'h50: c = 7'h32; 7'h51: c = 7'h33; 7'h52: c = 7'h30;
      7'h53: c = 7'h2E;
      default: c = '0;
    endcase
    return c;
  endfunction

  function automatic logic [CharWidth-1:0] upper_char(input logic [IdWidth-1:0] id);
    logic [CharWidth-1:0] c;
    unique case (id)
      7'h02: c = 7'h21; 7'h03: c = 7'h40; 7'h04: c = 7'h23; 7'h05: c = 7'h24;
      7'h06: c = 7'h25; 7'h07: c = 7'h5E; 7'h08: c = 7'h26; 7'h09: c = 7'h2A;
      7'h0A: c = 7'h28; 7'h0B: c = 7'h29; 7'h0C: c = 7'h5F; 7'h0D: c = 7'h2B;
      7'h0E: c = 7'h08; 7'h0F: c = 7'h09;
      7'h10: c = 7'h51; 7'h11: c = 7'h57; 7'h12: c = 7'h45; 7'h13: c = 7'h52;
      7'h14: c = 7'h54; 7'h15: c = 7'h59; 7'h16: c = 7'h55; 7'h17: c = 7'h49;
      7'h18: c = 7'h4F; 7'h19: c = 7'h50; 7'h1A: c = 7'h7B; 7'h1B: c = 7'h7D;
      7'h1C: c = 7'h0A; 7'h1E: c = 7'h41; 7'h1F: c = 7'h53;
      7'h20: c = 7'h44; 7'h21: c = 7'h46; 7'h22: c = 7'h47; 7'h23: c = 7'h48;
      7'h24: c = 7'h4A; 7'h25: c = 7'h4B; 7'h26: c = 7'h4C; 7'h27: c = 7'h3A;
      7'h28: c = 7'h22; 7'h29: c = 7'h7E; 7'h2B: c = 7'h7C; 7'h2C: c = 7'h5A;
      7'h2D: c = 7'h58; 7'h2E: c = 7'h43; 7'h2F: c = 7'h56;
      7'h30: c = 7'h42; 7'h31: c = 7'h4E; 7'h32: c = 7'h4D; 7'h33: c = 7'h3C;
      7'h34: c = 7'h3E; 7'h35: c = 7'h3F; 7'h37: c = 7'h2A; 7'h39: c = 7'h20;
      7'h47: c = 7'h0D; 7'h4A: c = 7'h2D; 7'h4C: c = 7'h35; 7'h4E: c = 7'h2B;
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== src/scancode_set1_to_ascii_decoder.sv =====
// A byte accepted into the input register is decoded from there and its
// item is presented from the result register. Throughput: one byte per
// cycle unless output stalls; the two registers form a two-stage pipe.
// Prefix bytes produce no item. Reset (asynchronous, active low) clears all
// modifier and lock flags, the pending-extended flag and both valid bits.
`default_nettype none

module scancode_set1_to_ascii_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] scan_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [6:0] key_id, [13:7] ascii_char, [14] shift_held, [15] ctrl_held,
  // [16] alt_held, [17] caps_lock_on, [18] num_lock_on, [19] insert_mode_on,
  // [23:20] zero
  output logic [23:0] m_axis_tdata,
  output logic [1:0]  m_axis_tuser   // [1:0] event_kind
);
  import sc1a_pkg::*;

  logic                 in_valid_q;
  logic [7:0]           in_byte_q;
  flags_t               flags_q;
  logic                 ext_q;
  logic                 out_valid_q;
  logic [IdWidth-1:0]   key_id_q;
  event_kind_e          kind_q;
  logic [CharWidth-1:0] char_q;
  flags_t               out_flags_q;

  logic    out_ready;
  logic    in_advance;
  decode_t dec;

  assign out_ready     = !out_valid_q || m_axis_tready;
  assign in_advance    = in_valid_q && out_ready;
  assign s_axis_tready = !in_valid_q || in_advance;

  sc1a_decode u_decode (
    .scan_byte_i (in_byte_q),
    .flags_i     (flags_q),
    .ext_i       (ext_q),
    .dec_o       (dec)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      flags_q     <= '0;
      ext_q       <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (in_advance) begin
        flags_q <= dec.flags_next;
        ext_q   <= dec.ext_next;
      end
      if (in_advance && dec.emit) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
    end
    if (in_advance && dec.emit) begin
      key_id_q    <= dec.key_id;
      kind_q      <= dec.kind;
      char_q      <= dec.ascii_char;
      out_flags_q <= dec.flags_next;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = kind_q;
  assign m_axis_tdata  = {4'b0000, out_flags_q.ins, out_flags_q.num, out_flags_q.caps,
                          out_flags_q.alt, out_flags_q.ctrl, out_flags_q.shift,
                          char_q, key_id_q};

  a_prefix_sets_ext : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_advance && in_byte_q == PREFIX_BYTE |=> ext_q)
    else $error("prefix byte did not set the pending-extended flag");

  a_byte_makes_item : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_advance && in_byte_q != PREFIX_BYTE |=> out_valid_q && !ext_q)
    else $error("non-prefix byte did not produce an item");

  a_release_no_char : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && kind_q != KIND_PRESS |-> char_q == '0)
    else $error("release or special item carries a character");

  a_shift_press : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && kind_q == KIND_PRESS && key_id_q == ID_LSHIFT |-> out_flags_q.shift)
    else $error("shift press did not set the shift flag");

endmodule

`default_nettype wire

// ===== src/sc1a_decode.sv =====
`default_nettype none

module sc1a_decode (
  input  logic [7:0]       scan_byte_i,
  input  sc1a_pkg::flags_t flags_i,
  input  logic             ext_i,
  output sc1a_pkg::decode_t dec_o
);
  import sc1a_pkg::*;

  logic [IdWidth-1:0]   id;
  logic                 up;
  logic                 special;
  logic                 is_pad;
  logic [CharWidth-1:0] raw_char;

  assign id       = scan_byte_i[6:0];
  assign up       = scan_byte_i[7];
  assign special  = ext_i || !flags_i.num;
  assign is_pad   = (id >= PAD_LOW) && (id <= PAD_HIGH);
  // The table choice and the case swap use the flags held before this item.
  assign raw_char = flags_i.shift ? upper_char(id) : lower_char(id);

  always_comb begin
    dec_o            = '0;
    dec_o.key_id     = id;
    dec_o.flags_next = flags_i;
    dec_o.kind       = KIND_PRESS;
    dec_o.ascii_char = '0;
    dec_o.ext_next   = 1'b0;
    dec_o.emit       = 1'b1;

    if (scan_byte_i == PREFIX_BYTE) begin
      dec_o.emit     = 1'b0;
      dec_o.ext_next = 1'b1;
    end else if (special && (id == ID_LALT || id == ID_LCTRL || is_pad)) begin
      if (id == ID_LALT) begin
        dec_o.flags_next.alt = !up;
      end else if (id == ID_LCTRL) begin
        dec_o.flags_next.ctrl = !up;
      end else if (!up && id == ID_INSERT) begin
        dec_o.flags_next.ins = !flags_i.ins;
      end
      dec_o.kind = up ? KIND_SPC_RELEASE : KIND_SPC_PRESS;
    end else begin
      if (id == ID_LSHIFT || id == ID_RSHIFT) begin
        dec_o.flags_next.shift = !up;
      end else if (id == ID_LALT) begin
        dec_o.flags_next.alt = !up;
      end else if (id == ID_LCTRL) begin
        dec_o.flags_next.ctrl = !up;
      end
      if (up) begin
        dec_o.kind = KIND_RELEASE;
      end else begin
        dec_o.ascii_char = raw_char;
        if (flags_i.caps) begin
          if (raw_char >= 7'h61 && raw_char <= 7'h7A) begin
            dec_o.ascii_char = raw_char - LETTER_CASE_STEP;
          end else if (raw_char >= 7'h41 && raw_char <= 7'h5A) begin
            dec_o.ascii_char = raw_char + LETTER_CASE_STEP;
          end
        end
        if (id == ID_NUMLK) begin
          dec_o.flags_next.num = !flags_i.num;
        end else if (id == ID_CAPS) begin
          dec_o.flags_next.caps = !flags_i.caps;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== sim/tb_scancode_set1_to_ascii_decoder.sv =====
module tb_scancode_set1_to_ascii_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  import sc1a_pkg::*;

  localparam int unsigned IdleLimit   = 2000;
  localparam int unsigned RandomItems = 1450;
  localparam int unsigned HoldCycles  = 80;
  localparam int unsigned TableLen    = 89;

  // Character maps indexed by key id, one byte per entry.
  localparam logic [0:88][7:0] PLAIN_MAP = {
    8'h00, 8'h00, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
    8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09,
    8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
    8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00, 8'h61, 8'h73,
    8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
    8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76,
    8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A,
    8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h37,
    8'h38, 8'h39, 8'h2D, 8'h34, 8'h35, 8'h36, 8'h2B, 8'h31,
    8'h32, 8'h33, 8'h30, 8'h2E, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00
  };

  localparam logic [0:88][7:0] SHIFT_MAP = {
    8'h00, 8'h00, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E,
    8'h26, 8'h2A, 8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09,
    8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
    8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h00, 8'h41, 8'h53,
    8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
    8'h22, 8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56,
    8'h42, 8'h4E, 8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h2A,
    8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h0D,
    8'h00, 8'h00, 8'h2D, 8'h00, 8'h35, 8'h00, 8'h2B, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00
  };

  typedef struct packed {
    logic [IdWidth-1:0]   key_id;
    event_kind_e          kind;
    logic [CharWidth-1:0] ch;
    flags_t               flags;
  } key_item_t;

  typedef struct packed {
    logic [7:0] scan;
    logic       typed;
    key_item_t  item;
  } dir_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  scancode_set1_to_ascii_decoder DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  // Predictor state.
  flags_t      kbd_flags;
  logic        kbd_ext_pending;
  key_item_t   key_q[$];

  int unsigned mismatches;
  int unsigned bytes_sent;
  int unsigned prefixes_sent;
  int unsigned keys_checked;
  int unsigned burst_left;
  bit          rx_holding;
  bit          rx_held_once;
  dir_row_t    dir_rows[$];

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Decodes one byte into the key item it produces, updating the flags.
  task automatic decode_scan(input logic [7:0] scan, output bit has_item,
                             output key_item_t item);
    logic [IdWidth-1:0]   id;
    logic                 up;
    logic                 extd;
    logic                 old_shift;
    logic                 old_caps;
    logic                 done;
    logic [CharWidth-1:0] ch;
    event_kind_e          kind;
    id        = scan[6:0];
    up        = scan[7];
    old_shift = kbd_flags.shift;
    old_caps  = kbd_flags.caps;
    ch        = '0;
    done      = 1'b0;
    kind      = KIND_PRESS;
    has_item  = 1'b0;
    item      = '0;
    if (scan == PREFIX_BYTE) begin
      kbd_ext_pending = 1'b1;
    end else begin
      extd = kbd_ext_pending;
      kbd_ext_pending = 1'b0;
      has_item = 1'b1;
      // Extended bytes, or any byte with num lock off, take the special path first.
      if (extd || !kbd_flags.num) begin
        if (id == ID_LALT) begin
          kbd_flags.alt = !up;
          kind = up ? KIND_SPC_RELEASE : KIND_SPC_PRESS;
          done = 1'b1;
        end else if (id == ID_LCTRL) begin
          kbd_flags.ctrl = !up;
          kind = up ? KIND_SPC_RELEASE : KIND_SPC_PRESS;
          done = 1'b1;
        end else begin
          if (!up && id == ID_INSERT) kbd_flags.ins = !kbd_flags.ins;
          if (id >= PAD_LOW && id <= PAD_HIGH) begin
            kind = up ? KIND_SPC_RELEASE : KIND_SPC_PRESS;
            done = 1'b1;
          end
        end
      end
      if (!done) begin
        if (id == ID_LSHIFT || id == ID_RSHIFT) kbd_flags.shift = !up;
        else if (id == ID_LALT) kbd_flags.alt = !up;
        else if (id == ID_LCTRL) kbd_flags.ctrl = !up;
        if (up) begin
          kind = KIND_RELEASE;
        end else begin
          kind = KIND_PRESS;
          if (id < TableLen) ch = old_shift ? SHIFT_MAP[id][6:0] : PLAIN_MAP[id][6:0];
          // Caps lock swaps the case of letters only.
          if (old_caps) begin
            if (ch >= 7'h61 && ch <= 7'h7A) ch = ch - LETTER_CASE_STEP;
            else if (ch >= 7'h41 && ch <= 7'h5A) ch = ch + LETTER_CASE_STEP;
          end
          if (id == ID_NUMLK) kbd_flags.num = !kbd_flags.num;
          else if (id == ID_CAPS) kbd_flags.caps = !kbd_flags.caps;
        end
      end
      item.key_id = id;
      item.kind   = kind;
      item.ch     = ch;
      item.flags  = kbd_flags;
    end
  endtask

  function automatic dir_row_t mk_row(input logic [7:0] scan, input logic typed,
                                      input logic [IdWidth-1:0] id, input event_kind_e kind,
                                      input logic [CharWidth-1:0] ch);
    dir_row_t r;
    r.scan        = scan;
    r.typed       = typed;
    r.item.key_id = id;
    r.item.kind   = kind;
    r.item.ch     = ch;
    r.item.flags  = '0;
    return r;
  endfunction

  // Offers one byte, waits for it to be taken and then applies the burst pattern.
  task automatic offer_byte(input logic [7:0] scan, input logic typed,
                            input key_item_t typed_item);
    bit        has_item;
    key_item_t item;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= scan;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    decode_scan(scan, has_item, item);
    if (has_item) key_q.push_back(typed ? typed_item : item);
    bytes_sent++;
    if (scan == PREFIX_BYTE) prefixes_sent++;
    @(negedge clk_i);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0 && !rx_holding) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= 8'($urandom);
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 200)
                                               : $urandom_range(1, 24);
    end
  endtask

  task automatic offer(input logic [7:0] scan);
    offer_byte(scan, 1'b0, '0);
  endtask

  function automatic logic [IdWidth-1:0] random_id();
    if ($urandom_range(0, 15) == 0) return 7'($urandom_range(7'h59, 7'h7F));
    return 7'($urandom_range(1, 7'h58));
  endfunction

  function automatic void cmp_field(input string name, input int unsigned exp_v,
                                    input int unsigned act_v);
    if (exp_v != act_v) begin
      mismatches++;
      $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, exp_v, act_v);
    end
  endfunction

  // Result checker.
  always @(posedge clk_i) begin
    key_item_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (key_q.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected item, expected none, got tdata 0x%06h tuser %0d",
                 $time, m_axis_tdata, m_axis_tuser);
      end else begin
        want = key_q.pop_front();
        keys_checked++;
        cmp_field("key_id", want.key_id, m_axis_tdata[6:0]);
        cmp_field("event_kind", want.kind, m_axis_tuser);
        cmp_field("ascii_char", want.ch, m_axis_tdata[13:7]);
        cmp_field("shift_held", want.flags.shift, m_axis_tdata[14]);
        cmp_field("ctrl_held", want.flags.ctrl, m_axis_tdata[15]);
        cmp_field("alt_held", want.flags.alt, m_axis_tdata[16]);
        cmp_field("caps_lock_on", want.flags.caps, m_axis_tdata[17]);
        cmp_field("num_lock_on", want.flags.num, m_axis_tdata[18]);
        cmp_field("insert_mode_on", want.flags.ins, m_axis_tdata[19]);
      end
    end
  end

  // Receiver: stall pattern drawn at random from four modes, with one long hold-off.
  initial begin
    int unsigned mode;
    int unsigned cyc;
    m_axis_tready = 1'b0;
    mode = 0;
    cyc  = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      cyc++;
      if (cyc % 64 == 0) mode = $urandom_range(0, 3);
      if (!rx_held_once && keys_checked >= 250) begin
        rx_holding = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        rx_holding   = 1'b0;
        rx_held_once = 1'b1;
      end else begin
        case (mode)
          0: begin
            m_axis_tready <= 1'b1;
          end
          1: begin
            m_axis_tready <= 1'($urandom_range(0, 1));
          end
          2: begin
            m_axis_tready <= ($urandom_range(0, 3) != 0);
          end
          default: begin
            m_axis_tready <= (cyc % 3 != 0);
          end
        endcase
      end
    end
  end

  // Watchdog on cycles where neither side moves an item.
  initial begin
    int unsigned idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("%0t: no item moved for %0d cycles", $time, IdleLimit);
        $display("scancode_set1_to_ascii_decoder: mismatch");
        $finish;
      end
    end
  end

  // Stimulus.
  initial begin
    logic [IdWidth-1:0] id;
    bit                 shifted;
    bit                 paused;
    int unsigned        pick;
    rst_ni          = 1'b0;
    s_axis_tvalid   = 1'b0;
    s_axis_tdata    = 8'h00;
    kbd_flags       = '0;
    kbd_ext_pending = 1'b0;
    mismatches      = 0;
    bytes_sent      = 0;
    prefixes_sent   = 0;
    keys_checked    = 0;
    burst_left      = 8;
    rx_holding      = 1'b0;
    rx_held_once    = 1'b0;
    paused          = 1'b0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Rows straight after reset have their items written out; the rest use the predictor.
    dir_rows.push_back(mk_row(8'h00, 1'b1, 7'h00, KIND_PRESS, 7'h00));
    dir_rows.push_back(mk_row(8'hFF, 1'b1, 7'h7F, KIND_RELEASE, 7'h00));
    dir_rows.push_back(mk_row(8'h7F, 1'b1, 7'h7F, KIND_PRESS, 7'h00));
    dir_rows.push_back(mk_row(8'h1E, 1'b1, 7'h1E, KIND_PRESS, 7'h61));
    dir_rows.push_back(mk_row(8'h9E, 1'b1, 7'h1E, KIND_RELEASE, 7'h00));
    // Shifted and plain quote, caps lock on a letter.
    dir_rows.push_back(mk_row(8'h2A, 1'b0, '0, KIND_PRESS, '0));
    dir_rows.push_back(mk_row(8'h28, 1'b0, '0, KIND_PRESS, '0));
    dir_rows.push_back(mk_row(8'hAA, 1'b0, '0, KIND_PRESS, '0));
    dir_rows.push_back(mk_row(8'h28, 1'b0, '0, KIND_PRESS, '0));
    dir_rows.push_back(mk_row(8'h3A, 1'b0, '0, KIND_PRESS, '0));
    dir_rows.push_back(mk_row(8'h10, 1'b0, '0, KIND_PRESS, '0));
    // Alt, ctrl, insert and keypad with num lock off.
    dir_rows.push_back(mk_row(8'h38, 1'b0, '0, KIND_PRESS, '0));
    dir_rows.push_back(mk_row(8'hB8, 1'b0, '0, KIND_PRESS, '0));
    dir_rows.push_back(mk_row(8'h1D, 1'b0, '0, KIND_PRESS, '0));
    dir_rows.push_back(mk_row(8'h52, 1'b0, '0, KIND_PRESS, '0));
    dir_rows.push_back(mk_row(8'h47, 1'b0, '0, KIND_PRESS, '0));
    dir_rows.push_back(mk_row(8'hD3, 1'b0, '0, KIND_PRESS, '0));
    // Num lock on: keypad decodes normally unless extended, also after a doubled prefix.
    dir_rows.push_back(mk_row(8'h45, 1'b0, '0, KIND_PRESS, '0));
    dir_rows.push_back(mk_row(8'h47, 1'b0, '0, KIND_PRESS, '0));
    dir_rows.push_back(mk_row(PREFIX_BYTE, 1'b0, '0, KIND_PRESS, '0));
    dir_rows.push_back(mk_row(PREFIX_BYTE, 1'b0, '0, KIND_PRESS, '0));
    dir_rows.push_back(mk_row(8'h47, 1'b0, '0, KIND_PRESS, '0));
    dir_rows.push_back(mk_row(PREFIX_BYTE, 1'b0, '0, KIND_PRESS, '0));
    dir_rows.push_back(mk_row(8'h9D, 1'b0, '0, KIND_PRESS, '0));
    dir_rows.push_back(mk_row(8'h3A, 1'b0, '0, KIND_PRESS, '0));
    dir_rows.push_back(mk_row(8'h45, 1'b0, '0, KIND_PRESS, '0));
    foreach (dir_rows[i]) offer_byte(dir_rows[i].scan, dir_rows[i].typed, dir_rows[i].item);

    // Random part: mostly well-formed key strokes, plus lock toggles and noise.
    while (bytes_sent < RandomItems + dir_rows.size()) begin
      if (!paused && bytes_sent >= 800) begin
        // Let the block drain completely once.
        s_axis_tvalid <= 1'b0;
        while (key_q.size() != 0) @(negedge clk_i);
        paused = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        id = random_id();
        shifted = ($urandom_range(0, 9) < 3);
        if (shifted) offer($urandom_range(0, 1) ? {1'b0, ID_LSHIFT} : {1'b0, ID_RSHIFT});
        if ($urandom_range(0, 6) == 0) offer(PREFIX_BYTE);
        offer({1'b0, id});
        if ($urandom_range(0, 6) == 0) offer(PREFIX_BYTE);
        offer({1'b1, id});
        if (shifted) offer($urandom_range(0, 1) ? {1'b1, ID_LSHIFT} : {1'b1, ID_RSHIFT});
      end else if (pick < 60) begin
        id = $urandom_range(0, 1) ? ID_CAPS : ID_NUMLK;
        offer({1'b0, id});
        offer({1'b1, id});
      end else if (pick < 72) begin
        id = $urandom_range(0, 1) ? ID_LALT : ID_LCTRL;
        if ($urandom_range(0, 2) == 0) offer(PREFIX_BYTE);
        offer({1'b0, id});
        if ($urandom_range(0, 2) == 0) offer(PREFIX_BYTE);
        offer({1'b1, id});
      end else if (pick < 85) begin
        id = $urandom_range(0, 3) == 0 ? ID_INSERT : 7'($urandom_range(PAD_LOW, PAD_HIGH));
        if ($urandom_range(0, 2) == 0) offer(PREFIX_BYTE);
        offer({1'b0, id});
        offer({1'b1, id});
      end else begin
        offer(8'($urandom_range(0, 255)));
      end
    end

    s_axis_tvalid <= 1'b0;
    while (key_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("Sent %0d scan bytes (%0d extended prefixes), checked %0d key items,",
             bytes_sent, prefixes_sent, keys_checked);
    $display("with bursty input, varied output stalls, one %0d-cycle hold-off and one drain.",
             HoldCycles);
    if (mismatches == 0) begin
      $display("scancode_set1_to_ascii_decoder: match");
    end else begin
      $display("scancode_set1_to_ascii_decoder: mismatch");
    end
    $finish;
  end

endmodule
